// File: rtl/pcx_rle_palette_decoder_defines.svh
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_defines.svh
// Assertion macros used by the palette decoder's sequencer module.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_PALETTE_DECODER_DEFINES_SVH
`define PCX_RLE_PALETTE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCXD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcxd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCXD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcxd: next-cycle check failed");

`endif

// File: rtl/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg
// Constants, types and helpers for the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int MAX_DIMENSION   = 1023;

   localparam int PAL_ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int DIM_W      = 10;
   localparam int PIX_W      = 2 * DIM_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [BYTE_W-1:0] PREFIX_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h3F;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_EMIT = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] count;
      logic               idx_ok;
   } seq_start_type;

   // 0 reads as 1, anything above the maximum saturates.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W+3:0] wide;
      logic [DIM_W-1:0] res;
      wide = {4'b0, v};
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (wide > (DIM_W+4)'(MAX_DIMENSION)) begin
         res = DIM_W'(MAX_DIMENSION);
      end else begin
         res = v;
      end
      return res;
   endfunction

   function automatic logic index_in_range(input logic [BYTE_W-1:0] idx);
      return ({1'b0, idx} < (BYTE_W+1)'(PALETTE_ENTRIES));
   endfunction

endpackage

// File: rtl/pcxd_ram.sv
// ----------------------------------------------------------------------------
// pcxd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcxd_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pcxd_seq.sv
// ----------------------------------------------------------------------------
// pcxd_seq
// Pixel sequencer: drains a run from the palette read data into the output
// register, one pixel per cycle unless stalled, and counts image pixels.
// ----------------------------------------------------------------------------
`include "pcx_rle_palette_decoder_defines.svh"

module pcxd_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  pcxd_pkg::seq_start_type      start,
   input  logic [pcxd_pkg::DIM_W-1:0]   width,
   input  logic [pcxd_pkg::DIM_W-1:0]   height,
   input  logic [pcxd_pkg::COLOR_W-1:0] color,
   output logic                         seq_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pcxd_pkg::CHAN_W-1:0]  rsp_red,
   output logic [pcxd_pkg::CHAN_W-1:0]  rsp_green,
   output logic [pcxd_pkg::CHAN_W-1:0]  rsp_blue,
   output logic                         rsp_run_last,
   output logic                         rsp_image_last
);

   pcxd_pkg::seq_state_type           state_ff, state_in;
   logic [pcxd_pkg::COUNT_W-1:0]      remaining_ff, remaining_in;
   logic                              idx_ok_ff, idx_ok_in;
   logic [pcxd_pkg::PIX_W-1:0]        pixels_done_ff, pixels_done_in;
   logic [pcxd_pkg::PIX_W-1:0]        total_ff, total_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pcxd_pkg::COLOR_W-1:0]      rsp_color_ff, rsp_color_in;
   logic                              rsp_run_last_ff, rsp_run_last_in;
   logic                              rsp_image_last_ff, rsp_image_last_in;

   logic                              load_out;
   logic                              last_img;
   logic                              last_run;
   logic                              finishing;
   logic [pcxd_pkg::PIX_W:0]          pixels_next;

   // Total is registered off the multiplier; the user must change dimensions only while idle, unenforced.
   assign total_in    = pcxd_pkg::PIX_W'(width) * pcxd_pkg::PIX_W'(height);
   assign pixels_next = {1'b0, pixels_done_ff} + 1'b1;
   assign last_img    = pixels_next >= {1'b0, total_ff};
   assign last_run    = last_img || (remaining_ff == pcxd_pkg::COUNT_W'(1));
   assign load_out    = (state_ff == pcxd_pkg::SEQ_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign finishing   = load_out && last_run;
   assign seq_ready   = (state_ff == pcxd_pkg::SEQ_IDLE) || finishing;

   always_comb begin
      state_in       = state_ff;
      remaining_in   = remaining_ff;
      idx_ok_in      = idx_ok_ff;
      pixels_done_in = pixels_done_ff;
      if (load_out) begin
         remaining_in   = remaining_ff - 1'b1;
         pixels_done_in = last_img ? '0 : pixels_next[pcxd_pkg::PIX_W-1:0];
      end
      if (finishing) begin
         state_in = pcxd_pkg::SEQ_IDLE;
      end
      if (start.start) begin
         state_in     = pcxd_pkg::SEQ_EMIT;
         remaining_in = start.count;
         idx_ok_in    = start.idx_ok;
      end
   end

   always_comb begin
      rsp_color_in      = rsp_color_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_image_last_in = rsp_image_last_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in      = 1'b1;
         rsp_color_in      = idx_ok_ff ? color : '0;
         rsp_run_last_in   = last_run;
         rsp_image_last_in = last_img;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pcxd_pkg::SEQ_IDLE;
         remaining_ff   <= '0;
         idx_ok_ff      <= 1'b0;
         pixels_done_ff <= '0;
         total_ff       <= pcxd_pkg::PIX_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         remaining_ff   <= remaining_in;
         idx_ok_ff      <= idx_ok_in;
         pixels_done_ff <= pixels_done_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff      <= rsp_color_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_image_last_ff <= rsp_image_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_color_ff[23:16];
   assign rsp_green      = rsp_color_ff[15:8];
   assign rsp_blue       = rsp_color_ff[7:0];
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_image_last = rsp_image_last_ff;

   `PCXD_ASSERT_IMP(a_start_only_when_ready, clock, reset, start.start, seq_ready)
   `PCXD_ASSERT_IMP(a_image_last_ends_run, clock, reset, rsp_valid_ff && rsp_image_last_ff, rsp_run_last_ff)
   `PCXD_ASSERT_NXT(a_idle_after_run, clock, reset, finishing && !start.start, state_ff == pcxd_pkg::SEQ_IDLE)
   `PCXD_ASSERT_NXT(a_pixel_count_steps, clock, reset, load_out && !last_img, pixels_done_ff == pcxd_pkg::PIX_W'($past(pixels_done_ff) + 1'b1))

endmodule

// File: rtl/pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// Decodes 8-bit PCX run-length bytes into RGB pixels through a palette RAM.
// ----------------------------------------------------------------------------
// Load items write the palette RAM. A data byte that is a plain byte or a
// run index starts a palette read, and the pixels are loaded into the
// output register from the next cycle on, one per cycle while the output
// is not stalled, with the next item taken in the cycle that loads the
// run's last pixel. A longer run therefore stalls the input until its last
// pixel is loaded; prefixes, loads and single pixels sustain one item per
// cycle while the output is not stalled. The palette read is registered and
// sits between taking an index and loading the first pixel. Palette reads
// and writes never share a cycle, as each item does one or the other.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [pcxd_pkg::BYTE_W-1:0]    req_entry_index,
   input  logic [pcxd_pkg::COLOR_W-1:0]   req_entry_color,
   input  logic [pcxd_pkg::BYTE_W-1:0]    req_code_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pcxd_pkg::CHAN_W-1:0]    rsp_red,
   output logic [pcxd_pkg::CHAN_W-1:0]    rsp_green,
   output logic [pcxd_pkg::CHAN_W-1:0]    rsp_blue,
   output logic                           rsp_run_last,
   output logic                           rsp_image_last,
   input  logic                           csr_write_enable,
   input  logic [pcxd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcxd_pkg::DIM_W-1:0]     csr_write_data
);

   logic [pcxd_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [pcxd_pkg::DIM_W-1:0]   height_ff, height_in;
   logic                         run_pending_ff, run_pending_in;
   logic [pcxd_pkg::COUNT_W-1:0] run_count_ff, run_count_in;

   logic                         seq_ready;
   logic                         req_accept;
   logic                         is_load;
   logic                         is_data;
   logic                         is_prefix;
   pcxd_pkg::seq_start_type      start;
   logic [pcxd_pkg::COLOR_W-1:0] pal_rd_data;

   assign req_stall  = !seq_ready;
   assign req_accept = req_valid && !req_stall;
   assign is_load    = req_accept && (req_command == pcxd_pkg::CMD_LOAD);
   assign is_data    = req_accept && (req_command == pcxd_pkg::CMD_DATA);
   assign is_prefix  = (req_code_byte & pcxd_pkg::PREFIX_MASK) == pcxd_pkg::PREFIX_MASK;

   // Registers hold the clamped dimensions.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pcxd_pkg::REG_IMAGE_WIDTH:  width_in  = pcxd_pkg::clamp_dim(csr_write_data);
            pcxd_pkg::REG_IMAGE_HEIGHT: height_in = pcxd_pkg::clamp_dim(csr_write_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      run_pending_in = run_pending_ff;
      run_count_in   = run_count_ff;
      start.start    = 1'b0;
      start.count    = pcxd_pkg::COUNT_W'(1);
      start.idx_ok   = pcxd_pkg::index_in_range(req_code_byte);
      if (is_data) begin
         if (run_pending_ff) begin
            // index byte of a pending run; a zero count yields nothing
            run_pending_in = 1'b0;
            run_count_in   = '0;
            start.count    = run_count_ff;
            start.start    = run_count_ff != '0;
         end else if (is_prefix) begin
            run_pending_in = 1'b1;
            run_count_in   = pcxd_pkg::COUNT_W'(req_code_byte & pcxd_pkg::COUNT_MASK);
         end else begin
            start.start = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= pcxd_pkg::DIM_W'(1);
         height_ff      <= pcxd_pkg::DIM_W'(1);
         run_pending_ff <= 1'b0;
         run_count_ff   <= '0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         run_pending_ff <= run_pending_in;
         run_count_ff   <= run_count_in;
      end
   end

   pcxd_ram #(
      .WIDTH (pcxd_pkg::COLOR_W),
      .DEPTH (pcxd_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (is_load && pcxd_pkg::index_in_range(req_entry_index)),
      .wr_addr (req_entry_index[pcxd_pkg::PAL_ADDR_W-1:0]),
      .wr_data (req_entry_color),
      .rd_en   (start.start),
      .rd_addr (req_code_byte[pcxd_pkg::PAL_ADDR_W-1:0]),
      .rd_data (pal_rd_data)
   );

   pcxd_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .width          (width_ff),
      .height         (height_ff),
      .color          (pal_rd_data),
      .seq_ready      (seq_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_run_last   (rsp_run_last),
      .rsp_image_last (rsp_image_last)
   );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCX run-length palette decoder. A table of
// directed items runs first under the reset image size, then random phases
// of palette loads, single pixels and runs under a range of image sizes.
// Every pixel is compared field by field against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 250;
   localparam int SETTLE       = 8;
   localparam int PHASE_ITEMS  = 42;
   localparam int NUM_PHASES   = 8;

   // Register indexes with no register behind them
   localparam logic [pcxd_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [pcxd_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [pcxd_pkg::CHAN_W-1:0] red;
      logic [pcxd_pkg::CHAN_W-1:0] green;
      logic [pcxd_pkg::CHAN_W-1:0] blue;
      logic                        run_last;
      logic                        image_last;
   } pixel_type;

   typedef struct packed {
      logic                         command;
      logic [pcxd_pkg::BYTE_W-1:0]  entry_index;
      logic [pcxd_pkg::COLOR_W-1:0] entry_color;
      logic [pcxd_pkg::BYTE_W-1:0]  code_byte;
      logic                         pinned;
      pixel_type                    pin;
   } req_item_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_command;
   logic [pcxd_pkg::BYTE_W-1:0]    req_entry_index;
   logic [pcxd_pkg::COLOR_W-1:0]   req_entry_color;
   logic [pcxd_pkg::BYTE_W-1:0]    req_code_byte;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [pcxd_pkg::CHAN_W-1:0]    rsp_red;
   logic [pcxd_pkg::CHAN_W-1:0]    rsp_green;
   logic [pcxd_pkg::CHAN_W-1:0]    rsp_blue;
   logic                           rsp_run_last;
   logic                           rsp_image_last;
   logic                           csr_write_enable;
   logic [pcxd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pcxd_pkg::DIM_W-1:0]     csr_write_data;

   // Pinned expectation travelling with the current request
   logic                           pin_now;
   pixel_type                      pin_pix;

   pcx_rle_palette_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_entry_index  (req_entry_index),
      .req_entry_color  (req_entry_color),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_last   (rsp_image_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Decoder state mirrored by the bench
   logic [pcxd_pkg::COLOR_W-1:0] palette [pcxd_pkg::PALETTE_ENTRIES];
   logic [pcxd_pkg::DIM_W-1:0]   img_w;
   logic [pcxd_pkg::DIM_W-1:0]   img_h;
   logic                         run_wait;
   logic [pcxd_pkg::COUNT_W-1:0] run_len;
   int                           pix_done;

   pixel_type pixel_q [$];
   int     errors      = 0;
   int     idle_cycles = 0;
   int     send_gap_max = 6;
   int     rsp_gap_max  = 6;
   bit     hold_req     = 1'b0;
   bit     loaded [pcxd_pkg::PALETTE_ENTRIES];

   function automatic int eff_dim(input logic [pcxd_pkg::DIM_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > pcxd_pkg::MAX_DIMENSION) return pcxd_pkg::MAX_DIMENSION;
      return int'(v);
   endfunction

   task automatic emit_pixels(input logic [pcxd_pkg::BYTE_W-1:0] idx, input int count);
      logic [pcxd_pkg::COLOR_W-1:0] color;
      int        total;
      pixel_type px;
      color = (int'(idx) < pcxd_pkg::PALETTE_ENTRIES) ? palette[idx] : '0;
      total = eff_dim(img_w) * eff_dim(img_h);
      for (int k = 0; k < count; k++) begin
         px.red        = color[23:16];
         px.green      = color[15:8];
         px.blue       = color[7:0];
         px.image_last = (pix_done + 1 >= total);
         px.run_last   = px.image_last || (k + 1 == count);
         pixel_q.push_back(px);
         if (px.image_last) begin
            pix_done = 0;
            break;
         end
         pix_done = pix_done + 1;
      end
   endtask

   task automatic decode_item(input logic cmd, input logic [pcxd_pkg::BYTE_W-1:0] idx,
                              input logic [pcxd_pkg::COLOR_W-1:0] color,
                              input logic [pcxd_pkg::BYTE_W-1:0] code);
      int cnt;
      if (cmd == pcxd_pkg::CMD_LOAD) begin
         if (int'(idx) < pcxd_pkg::PALETTE_ENTRIES) palette[idx] = color;
      end else if (run_wait) begin
         cnt      = int'(run_len);
         run_wait = 1'b0;
         run_len  = '0;
         emit_pixels(code, cnt);
      end else if ((code & pcxd_pkg::PREFIX_MASK) == pcxd_pkg::PREFIX_MASK) begin
         run_wait = 1'b1;
         run_len  = pcxd_pkg::COUNT_W'(code & pcxd_pkg::COUNT_MASK);
      end else begin
         emit_pixels(code, 1);
      end
   endtask

   task automatic check_pixel();
      pixel_type want;
      want = pixel_q.pop_front();
      if (rsp_red !== want.red) begin
         $error("red: expected %0h, got %0h", want.red, rsp_red);
         errors++;
      end
      if (rsp_green !== want.green) begin
         $error("green: expected %0h, got %0h", want.green, rsp_green);
         errors++;
      end
      if (rsp_blue !== want.blue) begin
         $error("blue: expected %0h, got %0h", want.blue, rsp_blue);
         errors++;
      end
      if (rsp_run_last !== want.run_last) begin
         $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
         errors++;
      end
      if (rsp_image_last !== want.image_last) begin
         $error("image_last: expected %0b, got %0b", want.image_last, rsp_image_last);
         errors++;
      end
   endtask

   // Monitor: results first, so a pixel can never match its own request
   always @(posedge clock) begin
      int n0;
      if (reset) begin
         for (int i = 0; i < pcxd_pkg::PALETTE_ENTRIES; i++) palette[i] = '0;
         img_w       = pcxd_pkg::DIM_W'(1);
         img_h       = pcxd_pkg::DIM_W'(1);
         run_wait    = 1'b0;
         run_len     = '0;
         pix_done    = 0;
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (pixel_q.size() == 0) begin
               $error("pixel transfer with nothing expected: %0h %0h %0h",
                      rsp_red, rsp_green, rsp_blue);
               errors++;
            end else begin
               check_pixel();
            end
         end
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            n0 = pixel_q.size();
            decode_item(req_command, req_entry_index, req_entry_color, req_code_byte);
            if (pin_now) begin
               while (pixel_q.size() > n0) void'(pixel_q.pop_back());
               pixel_q.push_back(pin_pix);
            end
         end
         if (csr_write_enable) begin
            idle_cycles = 0;
            if (csr_index == pcxd_pkg::REG_IMAGE_WIDTH) img_w = csr_write_data;
            else if (csr_index == pcxd_pkg::REG_IMAGE_HEIGHT) img_h = csr_write_data;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("pcx_rle_palette_decoder test failed");
      $finish;
   end

   // Receiver: random stall before each transfer, one long hold on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = hold_req ? HOLD_CYCLES : $urandom_range(0, rsp_gap_max);
         hold_req = 1'b0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_item_type load_item(input logic [pcxd_pkg::BYTE_W-1:0] idx,
                                              input logic [pcxd_pkg::COLOR_W-1:0] color);
      req_item_type it;
      it.command     = pcxd_pkg::CMD_LOAD;
      it.entry_index = idx;
      it.entry_color = color;
      it.code_byte   = pcxd_pkg::BYTE_W'($urandom);
      it.pinned      = 1'b0;
      it.pin         = '0;
      return it;
   endfunction

   function automatic req_item_type data_item(input logic [pcxd_pkg::BYTE_W-1:0] code);
      req_item_type it;
      it.command     = pcxd_pkg::CMD_DATA;
      it.entry_index = pcxd_pkg::BYTE_W'($urandom);
      it.entry_color = pcxd_pkg::COLOR_W'($urandom);
      it.code_byte   = code;
      it.pinned      = 1'b0;
      it.pin         = '0;
      return it;
   endfunction

   function automatic req_item_type pinned_item(input logic [pcxd_pkg::BYTE_W-1:0] code,
                                                input logic [pcxd_pkg::COLOR_W-1:0] rgb,
                                                input logic rl, input logic il);
      req_item_type it;
      it        = data_item(code);
      it.pinned = 1'b1;
      it.pin    = '{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                    run_last: rl, image_last: il};
      return it;
   endfunction

   // Called and returns at a falling edge; valid stays high when no gap follows
   task automatic send_item(input req_item_type it);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= it.command;
      req_entry_index <= it.entry_index;
      req_entry_color <= it.entry_color;
      req_code_byte   <= it.code_byte;
      pin_now         <= it.pinned;
      pin_pix         <= it.pin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [pcxd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pcxd_pkg::DIM_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic send_load(input logic [pcxd_pkg::BYTE_W-1:0] idx);
      send_item(load_item(idx, pcxd_pkg::COLOR_W'($urandom)));
      loaded[idx] = 1'b1;
   endtask

   // Mostly plain pixels and runs; a load between a prefix and its index is the odd case
   task automatic random_phase(input int n_items);
      int sent;
      int pick;
      int cnt;
      logic [pcxd_pkg::BYTE_W-1:0] idx;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         idx  = pcxd_pkg::BYTE_W'($urandom_range(0, 255));
         if (pick < 15) begin
            send_load(idx);
            sent++;
         end else begin
            if (!loaded[idx]) begin
               send_load(idx);
               sent++;
            end
            if (pick < 50 && idx < pcxd_pkg::PREFIX_MASK) begin
               send_item(data_item(idx));
               sent++;
            end else begin
               cnt = $urandom_range(0, 9);
               if (cnt == 0) cnt = 0;
               else if (cnt == 1) cnt = 63;
               else if (cnt == 2) cnt = $urandom_range(9, 62);
               else cnt = $urandom_range(1, 8);
               send_item(data_item(pcxd_pkg::PREFIX_MASK |
                                   (pcxd_pkg::BYTE_W'(cnt) & pcxd_pkg::COUNT_MASK)));
               sent++;
               if (pick >= 92) begin
                  send_load(pcxd_pkg::BYTE_W'($urandom_range(0, 255)));
                  sent++;
               end
               send_item(data_item(idx));
               sent++;
            end
         end
      end
   endtask

   initial begin
      req_item_type dir_table [$];
      int ph_w [NUM_PHASES];
      int ph_h [NUM_PHASES];

      ph_w = '{0, 1023, 4, 16, 0, 7, 1, 1023};
      ph_h = '{0, 1023, 3, 16, 3, 1, 1023, 1};

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = pcxd_pkg::CMD_LOAD;
      req_entry_index  = '0;
      req_entry_color  = '0;
      req_code_byte    = '0;
      csr_write_enable = 1'b0;
      csr_index        = pcxd_pkg::REG_IMAGE_WIDTH;
      csr_write_data   = '0;
      pin_now          = 1'b0;
      pin_pix          = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;

      // Reset size is 1x1, so every pixel closes its run and the image
      dir_table.push_back(load_item(8'h00, 24'h000000));
      dir_table.push_back(load_item(8'hFF, 24'hFFFFFF));
      dir_table.push_back(load_item(8'h5A, 24'hA55AC3));
      dir_table.push_back(load_item(8'hBF, 24'h00FF00));
      dir_table.push_back(pinned_item(8'h00, 24'h000000, 1'b1, 1'b1));
      dir_table.push_back(pinned_item(8'hBF, 24'h00FF00, 1'b1, 1'b1));
      dir_table.push_back(data_item(8'hC1));
      dir_table.push_back(pinned_item(8'hFF, 24'hFFFFFF, 1'b1, 1'b1));
      // zero-length run swallows its index
      dir_table.push_back(data_item(8'hC0));
      dir_table.push_back(data_item(8'h5A));
      dir_table.push_back(pinned_item(8'h5A, 24'hA55AC3, 1'b1, 1'b1));
      // load between prefix and index keeps the run pending
      dir_table.push_back(data_item(8'hFF));
      dir_table.push_back(load_item(8'h5A, 24'h3C3C3C));
      dir_table.push_back(pinned_item(8'h5A, 24'h3C3C3C, 1'b1, 1'b1));
      dir_table.push_back(data_item(8'hC2));
      dir_table.push_back(pinned_item(8'h00, 24'h000000, 1'b1, 1'b1));
      dir_table.push_back(load_item(8'h00, 24'h123456));
      dir_table.push_back(pinned_item(8'h00, 24'h123456, 1'b1, 1'b1));
      dir_table.push_back(data_item(8'hC5));
      dir_table.push_back(data_item(8'hFF));
      loaded[8'h00] = 1'b1;
      loaded[8'hFF] = 1'b1;
      loaded[8'h5A] = 1'b1;
      loaded[8'hBF] = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[i]) send_item(dir_table[i]);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(pcxd_pkg::REG_IMAGE_WIDTH, pcxd_pkg::DIM_W'(ph_w[p]));
         write_csr(pcxd_pkg::REG_IMAGE_HEIGHT, pcxd_pkg::DIM_W'(ph_h[p]));
         if (p == 0) write_csr(REG_SPARE_LO, '1);
         if (p == 5) write_csr(REG_SPARE_HI, '0);
         csr_write_enable <= 1'b0;
         send_gap_max = (p == 2) ? 0 : 6;
         rsp_gap_max  = (p == 2) ? 0 : 6;
         // receiver holds off while the sender keeps offering
         if (p == 3) hold_req = 1'b1;
         random_phase(PHASE_ITEMS);
         drain();
      end

      repeat (2 * SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("pcx_rle_palette_decoder test passed");
      end else begin
         $display("pcx_rle_palette_decoder test failed");
      end
      $finish;
   end

endmodule

// File: pcx_rle_palette_decoder.f
+incdir+rtl
rtl/pcxd_pkg.sv
rtl/pcxd_ram.sv
rtl/pcxd_seq.sv
rtl/pcx_rle_palette_decoder.sv
dv/tb_top.sv
